@@ rtl/wavetable_window_synth_macros.svh @@
// Assertion helpers for the wavetable window synthesiser.
// Both expect clk and rst_n in the scope of use.
`ifndef WAVETABLE_WINDOW_SYNTH_MACROS_SVH
`define WAVETABLE_WINDOW_SYNTH_MACROS_SVH

// Same-cycle implication.
`define WWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wws_pkg.sv @@
package wws_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_COLUMN = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_RAMP   = 2'd1;
  localparam logic [1:0] CFG_THRESH = 2'd2;
  localparam logic [1:0] CFG_TLEN   = 2'd3;

  // field widths
  localparam int WIN_W  = 7;
  localparam int AMP_W  = 16;
  localparam int SMP_W  = 16;
  localparam int COL_W  = 12;
  localparam int IDX_W  = 10;
  localparam int POS_W  = 6;
  localparam int TLEN_W = 11;
  localparam int CFG_W  = 16;

  // shared divider: window * column fits 18 bits, divisor is a table length or a ramp length
  localparam int DVD_W  = WIN_W + COL_W - 1;
  localparam int DVS_W  = TLEN_W;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  // microcode
  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] ST_LOAD   = 4'd1;
  localparam logic [STEP_W-1:0] ST_START  = 4'd2;
  localparam logic [STEP_W-1:0] ST_COL    = 4'd3;
  localparam logic [STEP_W-1:0] ST_MODGO  = 4'd4;
  localparam logic [STEP_W-1:0] ST_MODW   = 4'd5;
  localparam logic [STEP_W-1:0] ST_RAMPGO = 4'd6;
  localparam logic [STEP_W-1:0] ST_RAMPW  = 4'd7;
  localparam logic [STEP_W-1:0] ST_PREP   = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMIT   = 4'd9;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_LOAD      = 3'd1,
    OP_START     = 3'd2,
    OP_SETUP     = 3'd3,
    OP_DIV_PHASE = 3'd4,
    OP_DIV_RAMP  = 3'd5,
    OP_PREP      = 3'd6,
    OP_EMIT      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    J_NEXT     = 3'd0,
    J_GO       = 3'd1,
    J_DISPATCH = 3'd2,
    J_WAIT_DIV = 3'd3,
    J_SKIP     = 3'd4,
    J_EMIT     = 3'd5
  } jmp_t;

  typedef struct packed {
    op_t               op;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: OP_NONE, jmp: J_GO, target: ST_IDLE};
    case (step)
      ST_IDLE:   w = '{op: OP_NONE,      jmp: J_DISPATCH, target: ST_IDLE};
      ST_LOAD:   w = '{op: OP_LOAD,      jmp: J_GO,       target: ST_IDLE};
      ST_START:  w = '{op: OP_START,     jmp: J_GO,       target: ST_IDLE};
      ST_COL:    w = '{op: OP_SETUP,     jmp: J_SKIP,     target: ST_IDLE};
      ST_MODGO:  w = '{op: OP_DIV_PHASE, jmp: J_NEXT,     target: ST_IDLE};
      ST_MODW:   w = '{op: OP_NONE,      jmp: J_WAIT_DIV, target: ST_IDLE};
      ST_RAMPGO: w = '{op: OP_DIV_RAMP,  jmp: J_NEXT,     target: ST_IDLE};
      ST_RAMPW:  w = '{op: OP_NONE,      jmp: J_WAIT_DIV, target: ST_IDLE};
      ST_PREP:   w = '{op: OP_PREP,      jmp: J_NEXT,     target: ST_IDLE};
      ST_EMIT:   w = '{op: OP_EMIT,      jmp: J_EMIT,     target: ST_IDLE};
      default:   w = '{op: OP_NONE,      jmp: J_GO,       target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/wavetable_window_synth.sv @@
// Channel   Direction  Handshake              Word
// in_       in         in_valid / in_stall    command, table index/sample, amplitude, column
// out_      out        out_valid / out_stall  column, window position, contribution, last
// cfg_      in         cfg_write_en           register index, data (no read-back)
//
// A load or start-row word is done in its own microcode step. A column word out of range
// or with no samples stops at set-up; one giving n samples runs two passes of the shared
// divider (phase modulo and ramp step) and the set-up steps, then issues one sample a cycle
// unless out_stall holds it. Samples pass the read, multiply and round registers to the
// output; out_stall on a valid output freezes the whole sample pipeline and the issue loop
// with it. rst_n is synchronous, active low; the wavetable is not cleared.
`include "wavetable_window_synth_macros.svh"

module wavetable_window_synth #(
  parameter int MAX_WINDOW   = 64,
  parameter int TABLE_DEPTH  = 1024,
  parameter int GRID_COLUMNS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic [wws_pkg::IDX_W-1:0]           in_table_index,
  input  logic signed [wws_pkg::SMP_W-1:0]    in_table_sample,
  input  logic [wws_pkg::AMP_W-1:0]           in_amplitude,
  input  logic [wws_pkg::COL_W-1:0]           in_column,
  // result words
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [wws_pkg::COL_W-1:0]           out_column,
  output logic [wws_pkg::POS_W-1:0]           out_window_position,
  output logic signed [wws_pkg::SMP_W-1:0]    out_contribution,
  output logic                                out_last,
  // configuration
  input  logic                                cfg_write_en,
  input  logic [1:0]                          cfg_index,
  input  logic [wws_pkg::CFG_W-1:0]           cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [16:0] TD_LIM = 17'(TABLE_DEPTH);
  localparam logic [16:0] GC_LIM = 17'(GRID_COLUMNS);
  localparam logic [wws_pkg::WIN_W-1:0] WIN_MAX = wws_pkg::WIN_W'(MAX_WINDOW);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [wws_pkg::STEP_W-1:0] step_r, step_nxt;
  wws_pkg::ucode_t            uc;
  logic                       in_acc;

  assign uc       = wws_pkg::ucode_rom(step_r);
  assign in_stall = (step_r != wws_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // latched input word
  logic [wws_pkg::IDX_W-1:0]        idx_r;
  logic signed [wws_pkg::SMP_W-1:0] smp_r;
  logic [wws_pkg::AMP_W-1:0]        cur_r;
  logic [wws_pkg::COL_W-1:0]        col_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r <= in_table_index;
      smp_r <= in_table_sample;
      cur_r <= in_amplitude;
      col_r <= in_column;
    end
  end

  // configuration and row state
  logic [wws_pkg::WIN_W-1:0]  win_cfg_r, ramp_cfg_r;
  logic [wws_pkg::AMP_W-1:0]  thr_r;
  logic [wws_pkg::TLEN_W-1:0] tlen_cfg_r;
  logic [wws_pkg::AMP_W-1:0]  prev_amp_r;

  // per-column set-up
  logic [wws_pkg::WIN_W-1:0]  win_c, ramp_c, count_c;
  logic [wws_pkg::TLEN_W-1:0] tlen_c;
  logic                       in_range, skip;

  always_comb begin
    win_c  = (win_cfg_r > WIN_MAX) ? WIN_MAX : win_cfg_r;
    ramp_c = (ramp_cfg_r > win_c) ? win_c : ramp_cfg_r;
    if (tlen_cfg_r == '0) begin
      tlen_c = wws_pkg::TLEN_W'(1);
    end else if ({6'b0, tlen_cfg_r} > TD_LIM) begin
      tlen_c = wws_pkg::TLEN_W'(TABLE_DEPTH);
    end else begin
      tlen_c = tlen_cfg_r;
    end
    if (cur_r > thr_r) begin
      count_c = win_c;
    end else if (prev_amp_r > thr_r) begin
      count_c = ramp_c;
    end else begin
      count_c = '0;
    end
    in_range = {5'b0, col_r} < GC_LIM;
    skip     = !in_range || (count_c == '0);
  end

  // ---------------------------------------------------------------------------
  // Shared divider
  // ---------------------------------------------------------------------------
  wws_pkg::div_req_t div_req;
  wws_pkg::div_rsp_t div_rsp;

  logic [wws_pkg::AMP_W-1:0]  p_r;
  logic [wws_pkg::WIN_W-1:0]  win_r, ramp_r, count_r;
  logic [wws_pkg::TLEN_W-1:0] tlen_r;
  logic                       neg;
  logic [wws_pkg::AMP_W-1:0]  absd;

  always_comb begin
    neg  = cur_r < p_r;
    absd = neg ? (p_r - cur_r) : (cur_r - p_r);
    div_req.start    = (uc.op == wws_pkg::OP_DIV_PHASE) || (uc.op == wws_pkg::OP_DIV_RAMP);
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (uc.op)
      wws_pkg::OP_DIV_PHASE: begin
        div_req.dividend = wws_pkg::DVD_W'(win_r * col_r);
        div_req.divisor  = tlen_r;
      end
      wws_pkg::OP_DIV_RAMP: begin
        div_req.dividend = wws_pkg::DVD_W'(absd);
        div_req.divisor  = wws_pkg::DVS_W'(ramp_r);
      end
      default: begin
        div_req.dividend = '0;
        div_req.divisor  = '0;
      end
    endcase
  end

  wws_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Issue loop: phase walk and incremental ramp
  // ---------------------------------------------------------------------------
  // The ramp amplitude floor((P*(R-i) + C*i)/R) is tracked as quotient q and
  // remainder r of P*R + (C-P)*i, stepping by the floor-divided (C-P)/R.
  logic [wws_pkg::TLEN_W-1:0] phase_r;
  logic [wws_pkg::AMP_W-1:0]  qd_r, q_r;
  logic [wws_pkg::WIN_W-1:0]  rd_r, rrem_r;
  logic [wws_pkg::POS_W-1:0]  i_r;

  logic                       adv, issue, last_issue;
  logic [wws_pkg::WIN_W-1:0]  i_ext;
  logic [wws_pkg::AMP_W-1:0]  amp_sel;
  logic [wws_pkg::TLEN_W:0]   ph_inc;
  logic [wws_pkg::TLEN_W-1:0] phase_nxt;
  logic [wws_pkg::WIN_W:0]    r_sum;
  logic                       carry;
  logic [wws_pkg::WIN_W-1:0]  rrem_nxt;
  logic [wws_pkg::AMP_W-1:0]  q_nxt;
  logic [wws_pkg::AMP_W-1:0]  qa;
  logic [wws_pkg::WIN_W-1:0]  ra;

  logic out_valid_r;

  always_comb begin
    adv        = !out_valid_r || !out_stall;
    issue      = (uc.op == wws_pkg::OP_EMIT) && adv;
    i_ext      = {1'b0, i_r};
    last_issue = (i_ext + wws_pkg::WIN_W'(1)) == count_r;
    amp_sel    = (i_ext < ramp_r) ? q_r : cur_r;
    ph_inc     = {1'b0, phase_r} + (wws_pkg::TLEN_W + 1)'(1);
    phase_nxt  = (ph_inc >= {1'b0, tlen_r}) ? '0 : ph_inc[wws_pkg::TLEN_W-1:0];
    r_sum      = {1'b0, rrem_r} + {1'b0, rd_r};
    carry      = r_sum >= {1'b0, ramp_r};
    rrem_nxt   = carry ? wws_pkg::WIN_W'(r_sum - {1'b0, ramp_r})
                       : r_sum[wws_pkg::WIN_W-1:0];
    q_nxt      = q_r + qd_r + {{(wws_pkg::AMP_W-1){1'b0}}, carry};
    qa         = div_rsp.quotient[wws_pkg::AMP_W-1:0];
    ra         = div_rsp.remainder[wws_pkg::WIN_W-1:0];
  end

  // step counter
  always_comb begin
    step_nxt = step_r;
    case (uc.jmp)
      wws_pkg::J_NEXT: step_nxt = step_r + wws_pkg::STEP_W'(1);
      wws_pkg::J_GO:   step_nxt = uc.target;
      wws_pkg::J_DISPATCH: begin
        if (in_acc) begin
          case (in_command)
            wws_pkg::CMD_LOAD:   step_nxt = wws_pkg::ST_LOAD;
            wws_pkg::CMD_START:  step_nxt = wws_pkg::ST_START;
            wws_pkg::CMD_COLUMN: step_nxt = wws_pkg::ST_COL;
            default:             step_nxt = wws_pkg::ST_IDLE;
          endcase
        end
      end
      wws_pkg::J_WAIT_DIV: begin
        if (!div_rsp.busy) begin
          step_nxt = step_r + wws_pkg::STEP_W'(1);
        end
      end
      wws_pkg::J_SKIP: step_nxt = skip ? uc.target : step_r + wws_pkg::STEP_W'(1);
      wws_pkg::J_EMIT: begin
        if (issue && last_issue) begin
          step_nxt = uc.target;
        end
      end
      default: step_nxt = wws_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= wws_pkg::ST_IDLE;
      win_cfg_r  <= wws_pkg::WIN_W'(64);
      ramp_cfg_r <= wws_pkg::WIN_W'(16);
      thr_r      <= '0;
      tlen_cfg_r <= wws_pkg::TLEN_W'(1024);
      prev_amp_r <= '0;
    end else begin
      step_r <= step_nxt;
      if (cfg_write_en) begin
        case (cfg_index)
          wws_pkg::CFG_WINDOW: win_cfg_r  <= cfg_data[wws_pkg::WIN_W-1:0];
          wws_pkg::CFG_RAMP:   ramp_cfg_r <= cfg_data[wws_pkg::WIN_W-1:0];
          wws_pkg::CFG_THRESH: thr_r      <= cfg_data;
          wws_pkg::CFG_TLEN:   tlen_cfg_r <= cfg_data[wws_pkg::TLEN_W-1:0];
          default: ;
        endcase
      end
      // a start word sets the previous amplitude; an in-range column hands it on
      if (uc.op == wws_pkg::OP_START || (uc.op == wws_pkg::OP_SETUP && in_range)) begin
        prev_amp_r <= cur_r;
      end
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    case (uc.op)
      wws_pkg::OP_SETUP: begin
        p_r     <= prev_amp_r;
        win_r   <= win_c;
        ramp_r  <= ramp_c;
        tlen_r  <= tlen_c;
        count_r <= count_c;
      end
      wws_pkg::OP_DIV_RAMP: begin
        phase_r <= div_rsp.remainder;
      end
      wws_pkg::OP_PREP: begin
        // floor division of a negative step: negate, and borrow one on a remainder
        if (!neg) begin
          qd_r <= qa;
          rd_r <= ra;
        end else if (ra == '0) begin
          qd_r <= -qa;
          rd_r <= '0;
        end else begin
          qd_r <= ~qa;
          rd_r <= ramp_r - ra;
        end
        q_r    <= p_r;
        rrem_r <= '0;
        i_r    <= '0;
      end
      wws_pkg::OP_EMIT: begin
        if (issue) begin
          phase_r <= phase_nxt;
          q_r     <= q_nxt;
          rrem_r  <= rrem_nxt;
          i_r     <= i_r + wws_pkg::POS_W'(1);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Wavetable
  // ---------------------------------------------------------------------------
  logic signed [wws_pkg::SMP_W-1:0] wave_mem [0:TABLE_DEPTH-1];
  logic signed [wws_pkg::SMP_W-1:0] rdat_r;

  always_ff @(posedge clk) begin
    if (uc.op == wws_pkg::OP_LOAD && ({7'b0, idx_r} < TD_LIM)) begin
      wave_mem[AW'(idx_r)] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rdat_r <= wave_mem[AW'(phase_r)];
    end
  end

  // ---------------------------------------------------------------------------
  // Sample pipeline: read, multiply, round; frozen as a whole by out_stall
  // ---------------------------------------------------------------------------
  logic                             v1_r, v2_r;
  logic [wws_pkg::AMP_W-1:0]        amp1_r;
  logic [wws_pkg::POS_W-1:0]        pos1_r, pos2_r, pos_o_r;
  logic                             last1_r, last2_r, last_o_r;
  logic [wws_pkg::COL_W-1:0]        col1_r, col2_r, col_o_r;
  logic signed [32:0]               prod_r;
  logic signed [33:0]               rnd;
  logic signed [17:0]               shr;
  logic signed [wws_pkg::SMP_W-1:0] sat;
  logic signed [wws_pkg::SMP_W-1:0] contrib_r;

  always_comb begin
    rnd = 34'(prod_r) + 34'sd32768;
    shr = rnd[33:16];
    if (shr > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (shr < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = shr[wws_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      amp1_r    <= amp_sel;
      pos1_r    <= i_r;
      last1_r   <= last_issue;
      col1_r    <= col_r;
      prod_r    <= 33'(rdat_r) * 33'($signed({1'b0, amp1_r}));
      pos2_r    <= pos1_r;
      last2_r   <= last1_r;
      col2_r    <= col1_r;
      contrib_r <= sat;
      pos_o_r   <= pos2_r;
      last_o_r  <= last2_r;
      col_o_r   <= col2_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_column          = col_o_r;
  assign out_window_position = pos_o_r;
  assign out_contribution    = contrib_r;
  assign out_last            = last_o_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `WWS_ASSERT_IMP(a_div_idle, step_r == wws_pkg::ST_IDLE, !div_rsp.busy, "divider busy at idle")
  `WWS_ASSERT_IMP(a_pos_range, issue, i_ext < count_r, "sample issued beyond count")
  `WWS_ASSERT_IMP(a_phase_range, step_r == wws_pkg::ST_EMIT, phase_r < tlen_r, "phase past table")
  `WWS_ASSERT_IMP(a_ramp_rem, step_r == wws_pkg::ST_EMIT && ramp_r != '0, rrem_r < ramp_r, "ramp remainder")
  `WWS_ASSERT_NXT(a_emit_done, issue && last_issue, step_r == wws_pkg::ST_IDLE, "no return to idle")

endmodule

@@ rtl/wws_div.sv @@
// Restoring divider, one quotient bit a cycle.
module wws_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wws_pkg::div_req_t req,
  output wws_pkg::div_rsp_t rsp
);

  logic                       busy_r;
  logic [wws_pkg::DCNT_W-1:0] cnt_r;
  logic [wws_pkg::DVD_W-1:0]  work_r;
  logic [wws_pkg::DVS_W-1:0]  rem_r;
  logic [wws_pkg::DVS_W-1:0]  dvs_r;

  logic [wws_pkg::DVS_W:0]    rem_sh;
  logic [wws_pkg::DVS_W:0]    diff;
  logic                       fits;

  always_comb begin
    rem_sh = {rem_r, work_r[wws_pkg::DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    fits   = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= wws_pkg::DCNT_W'(wws_pkg::DVD_W);
    end else if (busy_r) begin
      busy_r <= (cnt_r != wws_pkg::DCNT_W'(1));
      cnt_r  <= cnt_r - wws_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work_r <= req.dividend;
      rem_r  <= '0;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      work_r <= {work_r[wws_pkg::DVD_W-2:0], fits};
      rem_r  <= fits ? diff[wws_pkg::DVS_W-1:0] : rem_sh[wws_pkg::DVS_W-1:0];
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.quotient  = work_r;
  assign rsp.remainder = rem_r;

endmodule
